>>> hdl/ibs_pkg.sv
// package for the in-place binomial smoother
// holds the stage fill state type used by the stage
// no dependencies
package ibs_pkg;

    // fill state of one smoothing stage
    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_FIRST = 2'd1,
        FILL_INNER = 2'd2
    } t_fill;

endpackage

>>> hdl/inplace_binomial_smoother.sv
// top level: chain of PASSES binomial smoothing stages
// depends on ibs_stage
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+----------------------------------
//   input    | in        | i_in_valid / o_in_stall  | i_accel_sample, i_is_last
//   result   | out       | o_out_valid / i_out_stall| o_smoothed_accel, o_last_out
//
// one request per cycle is taken unless a stall is raised; each stage adds one register of
// latency and holds one sample of lookahead, so results of a sequence start after
// PASSES+1 requests. the request flagged last flushes every held sample: each stage
// emits its held last sample in its own flush step, stalling its upstream side meanwhile.
// reset is synchronous, active low, and empties every stage and result register.
// a stall on the result side propagates back through the stage chain in the same cycle.
module inplace_binomial_smoother #(
    parameter int PASSES      = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_sample,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_smoothed_accel,
    output logic                          o_last_out
);

    logic                          w_valid [PASSES+1];
    logic                          w_stall [PASSES+1];
    logic signed [SAMPLE_BITS-1:0] w_data  [PASSES+1];
    logic                          w_last  [PASSES+1];

    // chain ends
    assign w_valid[0]       = i_in_valid;
    assign w_data[0]        = i_accel_sample;
    assign w_last[0]        = i_is_last;
    assign o_in_stall       = w_stall[0];
    assign w_stall[PASSES]  = i_out_stall;
    assign o_out_valid      = w_valid[PASSES];
    assign o_smoothed_accel = w_data[PASSES];
    assign o_last_out       = w_last[PASSES];

    // smoothing passes
    for (genvar k = 0; k < PASSES; k++) begin : g_pass
        ibs_stage #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_in_valid (w_valid[k]),
            .o_in_stall (w_stall[k]),
            .i_in_data  (w_data[k]),
            .i_in_last  (w_last[k]),
            .o_out_valid(w_valid[k+1]),
            .i_out_stall(w_stall[k+1]),
            .o_out_data (w_data[k+1]),
            .o_out_last (w_last[k+1])
        );
    end

endmodule

>>> hdl/ibs_stage.sv
// one (1,2,1)/4 smoothing pass with one sample of lookahead and a result register
// depends on ibs_pkg for the fill state type
module ibs_stage #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_data,
    input  logic                          i_in_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_data,
    output logic                          o_out_last
);

    localparam int SUM_BITS = SAMPLE_BITS + 2;

    ibs_pkg::t_fill r_fill, n_fill;
    logic r_flush, n_flush;
    logic r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_held, n_held;
    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic signed [SAMPLE_BITS-1:0] r_out_data, n_out_data;
    logic r_out_last, n_out_last;

    logic can_load;
    logic in_fire;
    logic out_load;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SAMPLE_BITS-1:0] smooth;

    // handshake: result register free, no pending flush
    assign can_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_flush || !can_load;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_load   = n_out_valid && can_load;

    // prev + 2*held + next, floor divide by 4 by dropping two bits
    assign sum = {{2{r_prev[SAMPLE_BITS-1]}}, r_prev}
               + {r_held[SAMPLE_BITS-1], r_held, 1'b0}
               + {{2{i_in_data[SAMPLE_BITS-1]}}, i_in_data};
    assign smooth = sum[SUM_BITS-1:2];

    // next state and result
    always_comb begin
        n_fill      = r_fill;
        n_flush     = r_flush;
        n_held      = r_held;
        n_prev      = r_prev;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (can_load) begin
            n_out_valid = 1'b0;
        end
        if (r_flush) begin
            // emit the held last sample unchanged
            if (can_load) begin
                n_out_valid = 1'b1;
                n_out_data  = r_held;
                n_out_last  = 1'b1;
                n_fill      = ibs_pkg::FILL_EMPTY;
                n_flush     = 1'b0;
            end
        end else if (in_fire) begin
            case (r_fill)
                ibs_pkg::FILL_EMPTY: begin
                    if (i_in_last) begin
                        // single-sample sequence passes straight through
                        n_out_valid = 1'b1;
                        n_out_data  = i_in_data;
                        n_out_last  = 1'b1;
                    end else begin
                        n_held = i_in_data;
                        n_fill = ibs_pkg::FILL_FIRST;
                    end
                end
                ibs_pkg::FILL_FIRST, ibs_pkg::FILL_INNER: begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_fill == ibs_pkg::FILL_FIRST) ? r_held : smooth;
                    n_out_last  = 1'b0;
                    n_prev      = n_out_data;
                    n_held      = i_in_data;
                    n_fill      = ibs_pkg::FILL_INNER;
                    n_flush     = i_in_last;
                end
                default: begin
                    n_fill = ibs_pkg::FILL_EMPTY;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= ibs_pkg::FILL_EMPTY;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_prev     <= n_prev;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

`ifndef ASSERT_OFF
    // a pending flush always has an inner sample held
    a_flush_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_fill == ibs_pkg::FILL_INNER)
        else $error("flush pending without held inner sample");

    // last request on a filled stage schedules a flush
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_last && r_fill != ibs_pkg::FILL_EMPTY) |=> r_flush)
        else $error("last request did not schedule flush");

    // emitting a last result leaves the stage empty
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out_last) |=> (r_fill == ibs_pkg::FILL_EMPTY && !r_flush))
        else $error("stage not empty after last result");

    // no request accepted while the flush is pending
    a_flush_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !in_fire)
        else $error("request accepted during flush");
`endif

endmodule
